@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the SHA-1 block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SHA1BC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SHA1BC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays live through reset.
`define SHA1BC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sha1bc_pkg.sv @@
// Shared types and constants of the SHA-1 block compression unit.
// No dependencies; used by all modules.
package sha1bc_pkg;

    localparam int DIGEST_WORDS        = 5;
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    typedef logic [3:0] t_word_pos;
    typedef logic [2:0] t_digest_idx;
    typedef logic [0:DIGEST_WORDS-1][31:0] t_chain;
    typedef logic [0:3][31:0] t_round_consts;

    // Position of the last word in a 16-word block
    localparam t_word_pos   WORD_LAST       = 4'h0F;
    localparam t_digest_idx DIGEST_IDX_LAST = 3'(DIGEST_WORDS - 1);
    localparam logic [6:0]  ROUND_LAST      = 7'd79;
    localparam logic [6:0]  ROUND_EXP_FIRST = 7'd16;

    localparam t_chain CHAIN_IV = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam t_round_consts ROUND_K = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };

    // Input item
    typedef struct packed {
        logic [31:0] message_word;
        logic        new_message;
        logic        final_block;
    } t_msg_item;

    // Result item
    typedef struct packed {
        logic [31:0] digest_word;
        t_digest_idx digest_index;
        logic        last_word;
    } t_digest_item;

    // Classified word passed from the front to the back
    typedef struct packed {
        logic [31:0] word;
        t_word_pos   pos;
        logic        fresh;
        logic        fin;
    } t_q_entry;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EXPAND,
        ST_ADD,
        ST_EMIT
    } t_back_state;

endpackage

@@ rtl/sha1bc_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload types come from sha1bc_pkg at instantiation.
interface sha1bc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sha1bc_front.sv @@
// Front end: accepts message words, tracks block position and final flag.
// Depends on sha1bc_pkg and sha1bc_stream_if.
module sha1bc_front
    import sha1bc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1bc_stream_if.sink   i_msg,
    sha1bc_stream_if.source o_entry
);

    t_word_pos r_word_count;
    logic      r_final_pending;
    t_word_pos n_word_count;
    logic      n_final_pending;
    t_word_pos pos;
    logic      fin_acc;
    logic      push;

    // Classify: a new message restarts at word 0, final flag is sticky per block
    always_comb begin
        pos             = i_msg.payload.new_message ? '0 : r_word_count;
        fin_acc         = ((pos != '0) && r_final_pending) || i_msg.payload.final_block;
        push            = i_msg.valid && o_entry.ready;
        n_word_count    = push ? pos + 4'd1 : r_word_count;
        n_final_pending = push ? fin_acc : r_final_pending;
    end

    assign i_msg.ready           = o_entry.ready;
    assign o_entry.valid         = i_msg.valid;
    assign o_entry.payload.word  = i_msg.payload.message_word;
    assign o_entry.payload.pos   = pos;
    assign o_entry.payload.fresh = i_msg.payload.new_message;
    assign o_entry.payload.fin   = fin_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count    <= '0;
            r_final_pending <= 1'b0;
        end else begin
            r_word_count    <= n_word_count;
            r_final_pending <= n_final_pending;
        end
    end

endmodule

@@ rtl/sha1bc_queue.sv @@
// Word queue between front and back; lets either side stall on its own.
// Depends on sha1bc_pkg and sha1bc_stream_if.
module sha1bc_queue
    import sha1bc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1bc_stream_if.sink   i_push,
    sha1bc_stream_if.source o_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    t_q_entry         r_out;
    logic             r_out_valid;
    logic             do_push;
    logic             load_out;
    logic             from_mem;
    logic             push_mem;

    assign i_push.ready  = (r_count != CNT_W'(DEPTH));
    assign o_pop.valid   = r_out_valid;
    assign o_pop.payload = r_out;
    assign do_push       = i_push.valid && i_push.ready;

    // Output slot frees up when empty or taken this cycle
    assign load_out = !r_out_valid || o_pop.ready;
    assign from_mem = load_out && (r_count != '0);
    // Item goes straight to the output slot when storage is empty and the slot is free
    assign push_mem = do_push && !(load_out && (r_count == '0));

    // Storage write and registered read into the output slot
    always_ff @(posedge i_clk) begin
        if (push_mem) begin
            r_mem[r_wr_ptr] <= i_push.payload;
        end
        if (from_mem) begin
            r_out <= r_mem[r_rd_ptr];
        end else if (load_out && do_push) begin
            r_out <= i_push.payload;
        end
    end

    // Pointers, fill level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= from_mem || do_push;
            end
            if (push_mem) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (from_mem) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push_mem && !from_mem) begin
                r_count <= r_count + CNT_W'(1);
            end else if (from_mem && !push_mem) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/sha1bc_back.sv @@
// Back end: one SHA-1 round per cycle (rounds 0-15 wait for input words), chaining update and digest output.
// Depends on sha1bc_pkg and sha1bc_stream_if.
module sha1bc_back
    import sha1bc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1bc_stream_if.sink   i_entry,
    sha1bc_stream_if.source o_digest
);

    t_back_state r_state;
    t_back_state n_state;
    t_chain      r_chain;
    t_chain      r_wv;
    logic [31:0] r_w [16];
    logic [6:0]  r_round;
    logic        r_fin;
    t_digest_idx r_idx;

    t_chain      src;
    logic [6:0]  t_cur;
    logic [1:0]  phase;
    logic [31:0] w_exp;
    logic [31:0] w_t;
    logic [31:0] f_val;
    logic [31:0] tmp;
    logic        load_step;
    logic        exp_step;
    logic        emit_take;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_entry.valid && (i_entry.payload.pos == WORD_LAST)) begin
                    n_state = ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                if (r_round == ROUND_LAST) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = r_fin ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                if (o_digest.ready && (r_idx == DIGEST_IDX_LAST)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State outputs
    always_comb begin
        i_entry.ready  = 1'b0;
        o_digest.valid = 1'b0;
        exp_step       = 1'b0;
        unique case (r_state)
            ST_LOAD:   i_entry.ready  = 1'b1;
            ST_EXPAND: exp_step       = 1'b1;
            ST_ADD:    ;
            ST_EMIT:   o_digest.valid = 1'b1;
            default:   ;
        endcase
    end

    assign load_step = i_entry.valid && i_entry.ready;
    assign emit_take = o_digest.valid && o_digest.ready;

    assign o_digest.payload.digest_word  = r_chain[r_idx];
    assign o_digest.payload.digest_index = r_idx;
    assign o_digest.payload.last_word    = (r_idx == DIGEST_IDX_LAST);

    // Round operands: word 0 of a block starts from the chaining value
    always_comb begin
        if (load_step && (i_entry.payload.pos == '0)) begin
            src = i_entry.payload.fresh ? CHAIN_IV : r_chain;
        end else begin
            src = r_wv;
        end
        t_cur = load_step ? {3'b000, i_entry.payload.pos} : r_round;
        w_exp = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_t   = load_step ? i_entry.payload.word : {w_exp[30:0], w_exp[31]};
        if (t_cur < 7'd20) begin
            phase = 2'd0;
        end else if (t_cur < 7'd40) begin
            phase = 2'd1;
        end else if (t_cur < 7'd60) begin
            phase = 2'd2;
        end else begin
            phase = 2'd3;
        end
    end

    // Round function and new A
    always_comb begin
        case (phase)
            2'd0:    f_val = (src[1] & src[2]) | (~src[1] & src[3]);
            2'd2:    f_val = (src[1] & src[2]) | (src[1] & src[3]) | (src[2] & src[3]);
            default: f_val = src[1] ^ src[2] ^ src[3];
        endcase
        tmp = {src[0][26:0], src[0][31:27]} + f_val + src[4] + ROUND_K[phase] + w_t;
    end

    // Control and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_chain <= CHAIN_IV;
            r_idx   <= '0;
            r_round <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_step) begin
                r_fin   <= i_entry.payload.fin;
                r_round <= ROUND_EXP_FIRST;
                if (i_entry.payload.fresh) begin
                    r_chain <= CHAIN_IV;
                end
            end
            if (exp_step) begin
                r_round <= r_round + 7'd1;
            end
            if (r_state == ST_ADD) begin
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_chain[i] <= r_chain[i] + r_wv[i];
                end
            end
            if (emit_take) begin
                r_idx <= (r_idx == DIGEST_IDX_LAST) ? '0 : r_idx + 3'd1;
            end
        end
    end

    // Working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (load_step || exp_step) begin
            r_wv[0] <= tmp;
            r_wv[1] <= src[0];
            r_wv[2] <= {src[1][1:0], src[1][31:2]};
            r_wv[3] <= src[2];
            r_wv[4] <= src[3];
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= w_t;
        end
    end

endmodule

@@ rtl/sha1_block_compression_unit.sv @@
// Channel      | Dir | Payload                                     | Handshake
// i_msg        | in  | message_word, new_message, final_block      | valid/ready
// o_digest     | out | digest_word, digest_index, last_word        | valid/ready
//
// Each word enters a queue at one per cycle while the queue has room; the single
// round unit runs rounds 0-15 one per word, then rounds 16-79 from the expanded
// schedule, then the chaining add, and on a final block offers the five digest
// words; it takes no word of the next block before then. Synchronous active-low
// reset loads the initial chaining value; no clearing pass. A stalled output holds
// the back end while the front keeps filling the queue until it is full.
// Top level: front classifier, word queue and round engine.
// Depends on sha1bc_pkg, sha1bc_stream_if, sha1bc_front, sha1bc_queue, sha1bc_back.
module sha1_block_compression_unit
    import sha1bc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sha1bc_stream_if.sink   i_msg,
    sha1bc_stream_if.source o_digest
);

    sha1bc_stream_if #(.t_payload(t_q_entry)) w_front_q ();
    sha1bc_stream_if #(.t_payload(t_q_entry)) w_q_back ();

    sha1bc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (i_msg),
        .o_entry (w_front_q)
    );

    sha1bc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_q),
        .o_pop   (w_q_back)
    );

    sha1bc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_q_back),
        .o_digest (o_digest)
    );

endmodule

@@ rtl/sha1bc_checker.sv @@
// Port-level checks of the digest output sequence, bound to the top level.
// Depends on sha1bc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sha1bc_checker
    import sha1bc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input t_digest_idx i_out_index,
    input logic        i_out_last
);

    // Last flag marks exactly the fifth digest word
    `SHA1BC_ASSERT_SAME(a_last_on_idx4, i_clk, i_rst_n, i_out_valid, i_out_last == (i_out_index == DIGEST_IDX_LAST), "last_word does not match digest_index")

    // Digest words follow one another in index order
    `SHA1BC_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last, i_out_valid && (i_out_index == $past(i_out_index) + 3'd1), "digest words out of sequence")

    // A stalled item keeps its place
    `SHA1BC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_index), "stalled digest item changed")

    // Nothing is offered right after reset
    `SHA1BC_ASSERT_NEXT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n, !i_out_valid, "output valid after reset")

endmodule

bind sha1_block_compression_unit sha1bc_checker u_sha1bc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_digest.valid),
    .i_out_ready (o_digest.ready),
    .i_out_index (o_digest.payload.digest_index),
    .i_out_last  (o_digest.payload.last_word)
);
